FILE: design/quadratic_probe_hash_table_defines.svh
// ----------------------------------------------------------------------------
// quadratic probe hash table assertion macros
// shared concurrent check forms, clocked on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_PROBE_HASH_TABLE_DEFINES_SVH
`define QUADRATIC_PROBE_HASH_TABLE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define QPHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define QPHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/qpht_pkg.sv
// ----------------------------------------------------------------------------
// qpht_pkg
// widths, codes and defaults shared by the hash table modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qpht_pkg;

  localparam int unsigned KEY_W          = 31;
  localparam int unsigned OP_W           = 2;
  localparam int unsigned STATUS_W       = 3;
  localparam int unsigned SLOT_W         = 4;
  localparam int unsigned SST_W          = 2;
  localparam int unsigned DIGIT_W        = 4;
  localparam int unsigned TABLE_SIZE_DEF = 16;

  // request kinds; the unused code behaves as a search
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_INSERTED    = 3'd0,
    STS_FULL        = 3'd1,
    STS_DELETED     = 3'd2,
    STS_DELETE_MISS = 3'd3,
    STS_FOUND       = 3'd4,
    STS_SEARCH_MISS = 3'd5
  } status_t;

  typedef enum logic [SST_W-1:0] {
    SST_EMPTY   = 2'd0,
    SST_USED    = 2'd1,
    SST_DELETED = 2'd2
  } slot_state_t;

endpackage

FILE: design/qpht_if.sv
// ----------------------------------------------------------------------------
// qpht request and response channels
// valid/ready channels carrying one request or one result per transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface qpht_req_if;
  import qpht_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [KEY_W-1:0] key;

  modport source (output valid, output op, output key, input ready);
  modport sink (input valid, input op, input key, output ready);
endinterface

interface qpht_rsp_if;
  import qpht_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;

  modport source (output valid, output status, output slot, input ready);
  modport sink (input valid, input status, input slot, output ready);
endinterface

FILE: design/qpht_mod.sv
// ----------------------------------------------------------------------------
// qpht_mod
// key modulo table size, four key bits per cycle, most significant first
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qpht_mod #(
  parameter int unsigned MODULUS = qpht_pkg::TABLE_SIZE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [qpht_pkg::KEY_W-1:0] key,
  output logic                       done,
  output logic [$clog2(MODULUS)-1:0] rem
);
  import qpht_pkg::*;

  localparam int unsigned AW     = $clog2(MODULUS);
  localparam int unsigned RW     = AW + 1;
  localparam int unsigned DIGITS = (KEY_W + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned PAD_W  = DIGITS * DIGIT_W;
  localparam int unsigned CW     = $clog2(DIGITS + 1);

  logic [PAD_W-1:0] shifter;
  logic [AW-1:0]    rem_q;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [RW-1:0]    acc;

  // fold one digit into the running remainder
  always_comb begin
    acc = {1'b0, rem_q};
    for (int b = 0; b < DIGIT_W; b++) begin
      acc = {acc[RW-2:0], shifter[PAD_W-1-b]};
      if (acc >= RW'(MODULUS)) begin
        acc = acc - RW'(MODULUS);
      end
    end
  end

  // digit sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIGITS);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and key shifter
  always_ff @(posedge clk) begin
    if (start) begin
      rem_q   <= '0;
      shifter <= PAD_W'(key);
    end else if (busy) begin
      rem_q   <= acc[AW-1:0];
      shifter <= shifter << DIGIT_W;
    end
  end

  assign rem = rem_q;

endmodule

FILE: design/qpht_mem.sv
// ----------------------------------------------------------------------------
// qpht_mem
// slot memory, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qpht_mem #(
  parameter int unsigned DEPTH = qpht_pkg::TABLE_SIZE_DEF,
  parameter int unsigned WIDTH = qpht_pkg::KEY_W + qpht_pkg::SST_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: design/quadratic_probe_hash_table.sv
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table
// open-addressing hash table, quadratic probing, one result per request
// ----------------------------------------------------------------------------
// throughput: one request at a time; the home slot comes from the modulo unit
//   and each probe takes one read of the slot memory port
// reset: a clearing pass marks every slot empty; no request is taken until
//   it ends
`timescale 1ns / 1ps
`include "quadratic_probe_hash_table_defines.svh"

module quadratic_probe_hash_table #(
  parameter int unsigned TABLE_SIZE = qpht_pkg::TABLE_SIZE_DEF
) (
  input logic       clk,
  input logic       rst,
  qpht_req_if.sink   req,
  qpht_rsp_if.source rsp
);
  import qpht_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_SIZE);
  localparam int unsigned RW = AW + 1;
  localparam int unsigned MW = KEY_W + SST_W;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_MOD    = 5'b00100,
    S_PROBE  = 5'b01000,
    S_FINISH = 5'b10000
  } fsm_t;

  fsm_t             fsm;
  logic [AW-1:0]    clr_addr;
  logic [OP_W-1:0]  op_q;
  logic [KEY_W-1:0] key_q;

  // probe sequence
  logic [AW-1:0] home;
  logic [AW-1:0] sq;
  logic [AW-1:0] delta;
  logic [AW-1:0] i_issue;
  logic          issue_on;
  logic          rd_valid;
  logic          rd_last;
  logic [AW-1:0] rd_idx;

  // pending result
  status_t       fin_status;
  logic [AW-1:0] fin_idx;
  logic          fin_we;
  logic [MW-1:0] fin_wdata;

  // response register
  logic                rsp_valid;
  logic [STATUS_W-1:0] rsp_status;
  logic [SLOT_W-1:0]   rsp_slot;

  logic          mod_start;
  logic          mod_done;
  logic [AW-1:0] mod_rem;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;
  logic [AW-1:0] addr;
  logic [MW-1:0] rdata;

  logic [RW-1:0] addr_sum;
  logic [RW-1:0] sq_sum;
  logic [RW-1:0] delta_sum;
  logic [AW-1:0] sq_next;
  logic [AW-1:0] delta_next;

  logic [SST_W-1:0] rd_state;
  logic [KEY_W-1:0] rd_key;
  logic             is_insert;
  logic             is_delete;
  logic             hit;
  logic             stop;
  logic             out_free;

  assign req.ready  = (fsm == S_IDLE);
  assign mod_start  = req.valid && req.ready;
  assign out_free   = !rsp_valid || rsp.ready;
  assign rsp.valid  = rsp_valid;
  assign rsp.status = rsp_status;
  assign rsp.slot   = rsp_slot;

  qpht_mod #(
    .MODULUS(TABLE_SIZE)
  ) u_mod (
    .clk  (clk),
    .rst  (rst),
    .start(mod_start),
    .key  (req.key),
    .done (mod_done),
    .rem  (mod_rem)
  );

  qpht_mem #(
    .DEPTH(TABLE_SIZE),
    .WIDTH(MW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(addr),
    .rdata(rdata)
  );

  // probe address, next square and next step, each reduced by one compare and subtract
  always_comb begin
    addr_sum  = {1'b0, home} + {1'b0, sq};
    sq_sum    = {1'b0, sq} + {1'b0, delta};
    delta_sum = {1'b0, delta} + RW'(2);
    if (addr_sum >= RW'(TABLE_SIZE)) begin
      addr_sum = addr_sum - RW'(TABLE_SIZE);
    end
    if (sq_sum >= RW'(TABLE_SIZE)) begin
      sq_sum = sq_sum - RW'(TABLE_SIZE);
    end
    if (delta_sum >= RW'(TABLE_SIZE)) begin
      delta_sum = delta_sum - RW'(TABLE_SIZE);
    end
    addr       = addr_sum[AW-1:0];
    sq_next    = sq_sum[AW-1:0];
    delta_next = delta_sum[AW-1:0];
  end

  // examine the slot that came back from memory
  always_comb begin
    rd_state  = rdata[KEY_W +: SST_W];
    rd_key    = rdata[KEY_W-1:0];
    is_insert = (op_q == OP_INSERT);
    is_delete = (op_q == OP_DELETE);
    if (is_insert) begin
      hit  = (rd_state != SST_USED);
      stop = hit;
    end else begin
      hit  = (rd_state == SST_USED) && (rd_key == key_q);
      stop = hit || (rd_state == SST_EMPTY);
    end
  end

  // memory write: clearing pass or the final update of a request
  always_comb begin
    if (fsm == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = {SST_EMPTY, {KEY_W{1'b0}}};
    end else begin
      mem_we    = (fsm == S_FINISH) && out_free && fin_we;
      mem_waddr = fin_idx;
      mem_wdata = fin_wdata;
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= S_CLEAR;
      clr_addr  <= '0;
      issue_on  <= 1'b0;
      rd_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // load a finished result, or drop the held one after its transfer
      if (fsm == S_FINISH && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (fsm)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(TABLE_SIZE - 1)) begin
            fsm <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (mod_start) begin
            fsm <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            fsm      <= S_PROBE;
            issue_on <= 1'b1;
            rd_valid <= 1'b0;
          end
        end
        S_PROBE: begin
          if (rd_valid && (stop || rd_last)) begin
            fsm      <= S_FINISH;
            issue_on <= 1'b0;
            rd_valid <= 1'b0;
          end else begin
            rd_valid <= issue_on;
            if (issue_on && (i_issue == AW'(TABLE_SIZE - 1))) begin
              issue_on <= 1'b0;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            fsm <= S_IDLE;
          end
        end
        default: begin
          fsm <= S_IDLE;
        end
      endcase
    end
  end

  // request capture, probe counters and result staging
  always_ff @(posedge clk) begin
    if (mod_start) begin
      op_q  <= req.op;
      key_q <= req.key;
    end
    if (fsm == S_MOD && mod_done) begin
      home    <= mod_rem;
      sq      <= '0;
      delta   <= AW'(1);
      i_issue <= '0;
    end
    if (fsm == S_PROBE && issue_on) begin
      rd_idx  <= addr;
      rd_last <= (i_issue == AW'(TABLE_SIZE - 1));
      i_issue <= i_issue + AW'(1);
      sq      <= sq_next;
      delta   <= delta_next;
    end
    if (fsm == S_PROBE && rd_valid && (stop || rd_last)) begin
      if (hit) begin
        fin_idx <= rd_idx;
        fin_we  <= is_insert || is_delete;
        if (is_insert) begin
          fin_status <= STS_INSERTED;
          fin_wdata  <= {SST_USED, key_q};
        end else if (is_delete) begin
          fin_status <= STS_DELETED;
          fin_wdata  <= {SST_DELETED, rd_key};
        end else begin
          fin_status <= STS_FOUND;
          fin_wdata  <= rdata;
        end
      end else begin
        fin_idx   <= '0;
        fin_we    <= 1'b0;
        fin_wdata <= rdata;
        if (is_insert) begin
          fin_status <= STS_FULL;
        end else if (is_delete) begin
          fin_status <= STS_DELETE_MISS;
        end else begin
          fin_status <= STS_SEARCH_MISS;
        end
      end
    end
    if (fsm == S_FINISH && out_free) begin
      rsp_status <= fin_status;
      rsp_slot   <= SLOT_W'(fin_idx);
    end
  end

  // checks
  `QPHT_ASSERT_NOW(a_write_phase, mem_we, (fsm == S_CLEAR) || (fsm == S_FINISH), "stray write")
  `QPHT_ASSERT_NEXT(a_finish_result, (fsm == S_FINISH) && out_free, rsp.valid, "no result")
  `QPHT_ASSERT_NEXT(a_accept_mod, req.valid && req.ready, fsm == S_MOD, "modulo not started")
  `QPHT_ASSERT_NOW(a_no_probe_read_stale, rd_valid, fsm == S_PROBE, "read data outside probing")

endmodule
